>>> rtl/core/paht_pkg.sv
// Shared types, codes and constants of the page access hotness tracker.
package paht_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_PAGES_DEF   = 4096;
  localparam int unsigned PAGE_SHIFT_DEF  = 21;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned ADDR_BITS    = 48;
  localparam int unsigned PAGE_IDX_W   = 12;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned BASE_W       = 27;
  localparam int unsigned CLK_W        = 32;
  localparam int unsigned FLAG_W       = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 27;
  // Width for frame and region arithmetic, wide enough for the base and for any frame when PAGE_SHIFT is at least 8
  localparam int unsigned SPAN_W       = 40;

  // Page flag bit positions
  localparam int unsigned FLAG_MAPPED  = 0;
  localparam int unsigned FLAG_HOT     = 1;
  localparam int unsigned FLAG_PENDING = 2;

  typedef enum logic [2:0] {
    OP_SAMPLE     = 3'd0,
    OP_APPLY_HOT  = 3'd1,
    OP_APPLY_COLD = 3'd2,
    OP_MAP        = 3'd3,
    OP_CLEAR      = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_DRAM  = 2'd0,
    KIND_NVM   = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_HOT  = 2'd1,
    REQ_COLD = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOT_WR_THR = 3'd0,
    CFG_HOT_RD_THR = 3'd1,
    CFG_COOL_THR   = 3'd2,
    CFG_BASE_FRAME = 3'd3,
    CFG_REQ_EN     = 3'd4
  } cfg_idx_e;

  // Configuration register file contents
  typedef struct packed {
    logic [THR_W-1:0]  hot_wr_thr;
    logic [THR_W-1:0]  hot_rd_thr;
    logic [THR_W-1:0]  cool_thr;
    logic [BASE_W-1:0] base_frame;
    logic              req_en;
  } cfg_t;

  // Decoded request handed from the front end to the entry update
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] kind;
    logic       hit;      // non-zero sample address inside the region
    logic       page_ok;  // page index below the page count
  } ctl_t;

endpackage

>>> rtl/core/paht_entry_upd.sv
// Read-modify-write datapath for one page entry and the cooling clock step.
module paht_entry_upd #(
  parameter int unsigned COUNT_WIDTH = paht_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned ENTRY_W = 3 * COUNT_WIDTH + paht_pkg::CLK_W + paht_pkg::FLAG_W
) (
  input  paht_pkg::ctl_t                 ctl_i,
  input  paht_pkg::cfg_t                 cfg_i,
  input  logic [paht_pkg::CLK_W-1:0]     gclk_i,
  input  logic [ENTRY_W-1:0]             entry_i,
  output logic [ENTRY_W-1:0]             entry_o,
  output logic                           wr_en_o,
  output paht_pkg::req_e                 req_o,
  output logic                           counted_o,
  output logic                           gclk_adv_o
);
  import paht_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH + 1 : THR_W + 1;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] dram;
    logic [COUNT_WIDTH-1:0] nvm;
    logic [COUNT_WIDTH-1:0] wr;
    logic [CLK_W-1:0]       lclk;
    logic [FLAG_W-1:0]      flags;
  } entry_t;

  entry_t                 ent;
  entry_t                 nxt;
  logic [COUNT_WIDTH-1:0] cnt_old;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] dram_n;
  logic [COUNT_WIDTH-1:0] nvm_n;
  logic [COUNT_WIDTH-1:0] wr_n;
  logic [CMP_W-1:0]       rd_sum;
  logic [CLK_W-1:0]       age;
  logic                   hot;
  logic                   kind_ok;

  assign ent = entry_t'(entry_i);

  // Select and bump the sampled counter, saturating at all ones
  always_comb begin
    case (ctl_i.kind)
      KIND_DRAM: cnt_old = ent.dram;
      KIND_NVM:  cnt_old = ent.nvm;
      default:   cnt_old = ent.wr;
    endcase
    cnt_inc = (&cnt_old) ? cnt_old : cnt_old + 1'b1;
  end

  assign kind_ok = (ctl_i.kind <= KIND_WRITE);
  assign dram_n  = (ctl_i.kind == KIND_DRAM)  ? cnt_inc : ent.dram;
  assign nvm_n   = (ctl_i.kind == KIND_NVM)   ? cnt_inc : ent.nvm;
  assign wr_n    = (ctl_i.kind == KIND_WRITE) ? cnt_inc : ent.wr;

  // Classify against the write and summed read thresholds
  assign rd_sum = CMP_W'(dram_n) + CMP_W'(nvm_n);
  assign hot    = (CMP_W'(wr_n) >= CMP_W'(cfg_i.hot_wr_thr)) ||
                  (rd_sum >= CMP_W'(cfg_i.hot_rd_thr));

  // Decay by the distance to the global clock; far enough away clears it
  assign age     = gclk_i - ent.lclk;
  assign cnt_dec = (age >= CLK_W'(COUNT_WIDTH)) ? '0 : (cnt_inc >> age[5:0]);

  // Apply the operation to the entry
  always_comb begin
    nxt        = ent;
    wr_en_o    = 1'b0;
    req_o      = REQ_NONE;
    counted_o  = 1'b0;
    gclk_adv_o = 1'b0;
    unique case (ctl_i.op) inside
      OP_SAMPLE: begin
        if (ctl_i.hit && ent.flags[FLAG_MAPPED] && kind_ok) begin
          counted_o = 1'b1;
          wr_en_o   = 1'b1;
          if (cfg_i.req_en) begin
            if (hot) begin
              if (!ent.flags[FLAG_HOT] || !ent.flags[FLAG_PENDING]) begin
                nxt.flags[FLAG_PENDING] = 1'b1;
                req_o = REQ_HOT;
              end
            end else begin
              if (ent.flags[FLAG_HOT] || !ent.flags[FLAG_PENDING]) begin
                nxt.flags[FLAG_PENDING] = 1'b1;
                req_o = REQ_COLD;
              end
            end
          end
          case (ctl_i.kind)
            KIND_DRAM: nxt.dram = cnt_dec;
            KIND_NVM:  nxt.nvm  = cnt_dec;
            default:   nxt.wr   = cnt_dec;
          endcase
          nxt.lclk   = gclk_i;
          gclk_adv_o = (CMP_W'(cnt_dec) > CMP_W'(cfg_i.cool_thr));
        end
      end
      OP_APPLY_HOT, OP_APPLY_COLD: begin
        wr_en_o = ctl_i.page_ok;
        nxt.flags[FLAG_PENDING] = 1'b0;
        if (ent.flags[FLAG_MAPPED]) begin
          nxt.flags[FLAG_HOT] = (ctl_i.op == OP_APPLY_HOT);
        end
      end
      OP_MAP: begin
        wr_en_o = ctl_i.page_ok;
        nxt.flags[FLAG_MAPPED] = 1'b1;
      end
      OP_CLEAR: begin
        wr_en_o = ctl_i.page_ok;
        nxt.flags[FLAG_MAPPED] = 1'b0;
        nxt.flags[FLAG_HOT]    = 1'b0;
        nxt.dram = '0;
        nxt.nvm  = '0;
        nxt.wr   = '0;
      end
      default: begin
        wr_en_o = 1'b0;
      end
    endcase
  end

  assign entry_o = ENTRY_W'(nxt);

endmodule

>>> rtl/core/page_access_hotness_tracker.sv
// Top level of the page access hotness tracker: front end, page store and control.
// Each request reads its page entry from the page store into a register at the
// accepting edge; the update state then writes the updated entry back and raises
// done_o for exactly one cycle with the result; start is taken again in the cycle
// that shows the result, and no new request is taken while one is in its update
// cycle. The receiver cannot stall done_o. After reset the block sweeps the page
// store to zero, one entry per cycle, and holds busy high during the sweep;
// configuration writes are taken at any time, also during the sweep.
module page_access_hotness_tracker #(
  parameter int unsigned NUM_PAGES   = paht_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT  = paht_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned COUNT_WIDTH = paht_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [paht_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [paht_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [2:0]                          opcode_i,
  input  logic [1:0]                          access_kind_i,
  input  logic [paht_pkg::ADDR_BITS-1:0]      sample_address_i,
  input  logic [paht_pkg::PAGE_IDX_W-1:0]     page_index_i,
  output logic                                done_o,
  output logic [1:0]                          request_o,
  output logic [paht_pkg::PAGE_IDX_W-1:0]     result_page_o,
  output logic                                sample_counted_o,
  output logic                                sample_foreign_o,
  output logic [paht_pkg::CLK_W-1:0]          cooling_clock_o
);
  import paht_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(NUM_PAGES);
  localparam int unsigned ENTRY_W = 3 * COUNT_WIDTH + CLK_W + FLAG_W;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic   [ADDR_W-1:0]         clr_q;
  cfg_t                        cfg_q;
  logic   [CLK_W-1:0]          gclk_q;

  logic                        accept;
  logic                        addr_nz;
  logic   [SPAN_W-1:0]         frame;
  logic   [SPAN_W-1:0]         base;
  logic   [SPAN_W-1:0]         diff;
  logic                        in_region;
  ctl_t                        ctl_d;
  ctl_t                        ctl_q;
  logic                        foreign_d;
  logic                        foreign_q;
  logic   [PAGE_IDX_W-1:0]     rpage_d;
  logic   [PAGE_IDX_W-1:0]     rpage_q;
  logic   [ADDR_W-1:0]         raddr;
  logic   [ADDR_W-1:0]         addr_q;

  logic   [ENTRY_W-1:0]        page_mem_q [NUM_PAGES];
  logic   [ENTRY_W-1:0]        rd_q;
  logic                        mem_we;
  logic                        mem_re;
  logic   [ADDR_W-1:0]         mem_waddr;
  logic   [ENTRY_W-1:0]        mem_wdata;

  logic   [ENTRY_W-1:0]        upd_entry;
  logic                        upd_wr_en;
  req_e                        upd_req;
  logic                        upd_counted;
  logic                        upd_adv;

  logic                        done_q;
  logic   [1:0]                request_q;
  logic                        counted_q;
  logic                        foreign_out_q;
  logic   [PAGE_IDX_W-1:0]     rpage_out_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);

  // Map the sample address onto a page of the tracked region
  assign addr_nz   = |sample_address_i;
  assign frame     = SPAN_W'(sample_address_i >> PAGE_SHIFT);
  assign base      = SPAN_W'(cfg_q.base_frame);
  assign diff      = frame - base;
  assign in_region = (frame >= base) && (diff < SPAN_W'(NUM_PAGES));

  always_comb begin
    ctl_d.op      = opcode_i;
    ctl_d.kind    = access_kind_i;
    ctl_d.hit     = addr_nz && in_region;
    ctl_d.page_ok = (32'(page_index_i) < 32'(NUM_PAGES));
    if (opcode_i == OP_SAMPLE) begin
      foreign_d = addr_nz && !in_region;
      rpage_d   = ctl_d.hit ? diff[PAGE_IDX_W-1:0] : '0;
      raddr     = ADDR_W'(diff);
    end else begin
      foreign_d = 1'b0;
      rpage_d   = page_index_i;
      raddr     = ADDR_W'(32'(page_index_i));
    end
  end

  // Hold the decoded request for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q     <= ctl_d;
      foreign_q <= foreign_d;
      rpage_q   <= rpage_d;
      addr_q    <= raddr;
    end
  end

  // Sequence the clearing sweep and the read and update cycles
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(NUM_PAGES - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // Page store: one write port, one registered read port
  assign mem_re    = accept;
  assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_EXEC) && upd_wr_en);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : upd_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) page_mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= page_mem_q[raddr];
  end

  paht_entry_upd #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_upd (
    .ctl_i      (ctl_q),
    .cfg_i      (cfg_q),
    .gclk_i     (gclk_q),
    .entry_i    (rd_q),
    .entry_o    (upd_entry),
    .wr_en_o    (upd_wr_en),
    .req_o      (upd_req),
    .counted_o  (upd_counted),
    .gclk_adv_o (upd_adv)
  );

  // Advance the cooling clock and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gclk_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_EXEC);
      if ((state_q == ST_EXEC) && upd_adv) gclk_q <= gclk_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      request_q     <= upd_req;
      counted_q     <= upd_counted;
      foreign_out_q <= foreign_q;
      rpage_out_q   <= rpage_q;
    end
  end

  assign done_o           = done_q;
  assign request_o        = request_q;
  assign sample_counted_o = counted_q;
  assign sample_foreign_o = foreign_out_q;
  assign result_page_o    = rpage_out_q;
  assign cooling_clock_o  = gclk_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hot_wr_thr <= THR_W'(4);
      cfg_q.hot_rd_thr <= THR_W'(8);
      cfg_q.cool_thr   <= THR_W'(18);
      cfg_q.base_frame <= '0;
      cfg_q.req_en     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HOT_WR_THR: cfg_q.hot_wr_thr <= cfg_data_i[THR_W-1:0];
        CFG_HOT_RD_THR: cfg_q.hot_rd_thr <= cfg_data_i[THR_W-1:0];
        CFG_COOL_THR:   cfg_q.cool_thr   <= cfg_data_i[THR_W-1:0];
        CFG_BASE_FRAME: cfg_q.base_frame <= cfg_data_i[BASE_W-1:0];
        CFG_REQ_EN:     cfg_q.req_en     <= cfg_data_i[0];
        default:        cfg_q.req_en     <= cfg_q.req_en;
      endcase
    end
  end

  // A result only follows an update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without update cycle");

  // The cooling clock only moves in an update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gclk_q != $past(gclk_q)) |-> $past(state_q == ST_EXEC))
    else $error("cooling clock moved outside an update");

  // The page store is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("page store read and write overlap");

  // A migration request comes only from a counted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (request_o != REQ_NONE)) |-> sample_counted_o)
    else $error("request without counted sample");

  // A counted sample is never foreign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && sample_counted_o) |-> !sample_foreign_o)
    else $error("sample both counted and foreign");

endmodule
